### design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### design/ssd_pkg.sv
// Types, command codes and segment tables for the seven-segment controller.
package ssd_pkg;

  typedef enum logic [2:0] {
    CMD_SET_SYMBOL = 3'd0,
    CMD_SET_NUMBER = 3'd1,
    CMD_CLEAR      = 3'd2,
    CMD_SET_STATE  = 3'd3,
    CMD_GET_STATE  = 3'd4,
    CMD_SHOW       = 3'd5
  } ssd_cmd_t;

  localparam logic [4:0]  SYMBOL_COUNT = 5'd20;
  // x / 10 == (x * 0xCCCD) >> 19 for every 16-bit x
  localparam logic [15:0] RECIP_TEN    = 16'hCCCD;
  localparam int          RECIP_SHIFT  = 19;
  localparam int          QUOT_W       = 13;

  // One display entry: on/off state and segment pattern a..g
  typedef struct packed {
    logic       on;
    logic [6:0] pattern;
  } ssd_entry_t;

  // Result of one item
  typedef struct packed {
    logic [6:0] segment_levels;
    logic       enable_level;
    logic       state_read;
    logic       error_flag;
  } ssd_result_t;

  function automatic logic [6:0] digit_seg(input logic [3:0] digit);
    logic [6:0] seg;
    case (digit)
      4'd0:    seg = 7'h3F;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5B;
      4'd3:    seg = 7'h4F;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6D;
      4'd6:    seg = 7'h7D;
      4'd7:    seg = 7'h07;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h6F;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

  function automatic logic [6:0] letter_seg(input logic [4:0] code);
    logic [6:0] seg;
    case (code)
      5'd0:    seg = 7'h77;
      5'd1:    seg = 7'h7C;
      5'd2:    seg = 7'h39;
      5'd3:    seg = 7'h5E;
      5'd4:    seg = 7'h79;
      5'd5:    seg = 7'h71;
      5'd6:    seg = 7'h3D;
      5'd7:    seg = 7'h76;
      5'd8:    seg = 7'h30;
      5'd9:    seg = 7'h1F;
      5'd10:   seg = 7'h38;
      5'd11:   seg = 7'h37;
      5'd12:   seg = 7'h3F;
      5'd13:   seg = 7'h73;
      5'd14:   seg = 7'h67;
      5'd15:   seg = 7'h70;
      5'd16:   seg = 7'h6D;
      5'd17:   seg = 7'h78;
      5'd18:   seg = 7'h3E;
      5'd19:   seg = 7'h6E;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage

### design/seven_segment_display_controller.sv
// Top level of the seven-segment display controller: register port, sequencer, memory, output.
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------------------
//   input   | in_valid / in_ready  | command, display_index, symbol_code, number, state
//   result  | out_valid / out_ready| segment_levels, enable_level, state_read, error
//   config  | psel, penable, pwrite| paddr, pwdata, prdata (polarity_mask at 0x0)
//
// One item at a time. A rejected item goes from acceptance straight to the done state;
// other commands pass the read state first; set number repeats the read state (divide by
// ten) and the digit state (write) for each digit written. The next item is taken once the
// sequencer is back in idle. Reset clears the polarity register and the entry valid bits,
// so all displays read blank and off. A stalled result waits in the output register while
// the next item is taken; the sequencer holds its own result until that register frees up.
module seven_segment_display_controller
  import ssd_pkg::*;
#(
  parameter int NUM_DISPLAYS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [3:0]  in_display_index,
  input  logic [4:0]  in_symbol_code,
  input  logic [15:0] in_number_value,
  input  logic        in_new_state,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_segment_levels,
  output logic        out_enable_level,
  output logic        out_state_read,
  output logic        out_error_flag,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

`include "assert_macros.svh"

  localparam int AW = (NUM_DISPLAYS > 1) ? $clog2(NUM_DISPLAYS) : 1;

  logic [3:0]    polarity_r;
  logic [AW-1:0] mem_raddr;
  ssd_entry_t    mem_rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  ssd_entry_t    mem_wdata;
  logic          res_valid;
  logic          res_take;
  ssd_result_t   res;
  logic          out_valid_r;
  ssd_result_t   out_r;

  // Single register: decode every write to it
  assign pready = 1'b1;
  assign prdata = {28'd0, polarity_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      polarity_r <= '0;
    end else if (psel && penable && pwrite && pready && (paddr == 2'd0)) begin
      polarity_r <= pwdata[3:0];
    end
  end

  ssd_ctrl #(
    .NUM_DISPLAYS (NUM_DISPLAYS),
    .AW           (AW)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_display_index (in_display_index),
    .in_symbol_code   (in_symbol_code),
    .in_number_value  (in_number_value),
    .in_new_state     (in_new_state),
    .polarity_mask    (polarity_r),
    .mem_raddr        (mem_raddr),
    .mem_rdata        (mem_rdata),
    .mem_we           (mem_we),
    .mem_waddr        (mem_waddr),
    .mem_wdata        (mem_wdata),
    .res_valid        (res_valid),
    .res_take         (res_take),
    .res              (res)
  );

  ssd_mem #(
    .DEPTH (NUM_DISPLAYS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Load the output register when it is empty or being drained
  assign res_take = res_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_segment_levels = out_r.segment_levels;
  assign out_enable_level   = out_r.enable_level;
  assign out_state_read     = out_r.state_read;
  assign out_error_flag     = out_r.error_flag;

  `ASSERT_CLK(a_one_item_at_a_time, (in_valid && in_ready) |=> !in_ready,
              "input accepted while an item is in progress")
  `ASSERT_NEVER(a_write_in_range, mem_we && (32'(mem_waddr) >= NUM_DISPLAYS),
                "entry write beyond the last display")
  `ASSERT_CLK(a_error_result_clean,
              (out_valid && out_error_flag) |->
              (out_segment_levels == 7'd0 && !out_enable_level && !out_state_read),
              "rejected item carries nonzero result fields")

endmodule

### design/ssd_mem.sv
// Display entry memory: one write port, one registered read port, per-entry valid bits.
module ssd_mem
  import ssd_pkg::*;
#(
  parameter int DEPTH = 4,
  parameter int AW    = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  ssd_entry_t    wdata,
  input  logic [AW-1:0] raddr,
  output ssd_entry_t    rdata
);

  ssd_entry_t       mem_r [DEPTH];
  logic [DEPTH-1:0] valid_r;
  ssd_entry_t       rd_data_r;
  logic             rd_valid_r;

  // Mark written entries; unwritten ones read as blank and off
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  // Write the array
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    rd_data_r  <= mem_r[raddr];
    rd_valid_r <= valid_r[raddr];
  end

  assign rdata = rd_valid_r ? rd_data_r : '0;

endmodule

### design/ssd_ctrl.sv
// Command sequencer: reads an entry and rewrites it or reports it, one digit per pass.
module ssd_ctrl
  import ssd_pkg::*;
#(
  parameter int NUM_DISPLAYS = 4,
  parameter int AW           = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    in_command,
  input  logic [3:0]    in_display_index,
  input  logic [4:0]    in_symbol_code,
  input  logic [15:0]   in_number_value,
  input  logic          in_new_state,
  input  logic [3:0]    polarity_mask,
  output logic [AW-1:0] mem_raddr,
  input  ssd_entry_t    mem_rdata,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output ssd_entry_t    mem_wdata,
  output logic          res_valid,
  input  logic          res_take,
  output ssd_result_t   res
);

  localparam logic [AW-1:0] LAST_POS = AW'(NUM_DISPLAYS - 1);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_DIGIT, S_DONE} state_t;

  state_t              state_r, state_nxt;
  logic [2:0]          cmd_r, cmd_nxt;
  logic [AW-1:0]       pos_r, pos_nxt;
  logic [4:0]          sym_r, sym_nxt;
  logic [15:0]         num_r, num_nxt;
  logic                nst_r, nst_nxt;
  logic [QUOT_W-1:0]   quot_r, quot_nxt;
  ssd_result_t         res_r, res_nxt;

  logic                item_err;
  logic [3:0]          pos_wide;
  logic                pol;
  logic [31:0]         product;
  logic [3:0]          rem;

  // Reject bad command, index out of range or symbol out of range
  always_comb begin
    item_err = (in_command > CMD_SHOW) || (in_display_index >= 4'(NUM_DISPLAYS)) ||
               ((in_command == CMD_SET_SYMBOL) && (in_symbol_code >= SYMBOL_COUNT));
  end

  // Polarity of the addressed display; displays past the mask use zero
  assign pos_wide = 4'(pos_r);
  assign pol      = (pos_wide < 4'd4) ? polarity_mask[pos_wide[1:0]] : 1'b0;

  // Divide by ten through the reciprocal; remainder from the registered quotient
  assign product = 32'(num_r) * 32'(RECIP_TEN);
  assign rem     = 4'(num_r - 16'(quot_r) * 16'd10);

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    pos_nxt   = pos_r;
    sym_nxt   = sym_r;
    num_nxt   = num_r;
    nst_nxt   = nst_r;
    quot_nxt  = quot_r;
    res_nxt   = res_r;
    mem_raddr = pos_r;
    mem_we    = 1'b0;
    mem_waddr = pos_r;
    mem_wdata = mem_rdata;

    case (state_r)
      S_IDLE: begin
        // Start the entry read with the item
        mem_raddr = in_display_index[AW-1:0];
        if (in_valid) begin
          cmd_nxt = in_command;
          pos_nxt = in_display_index[AW-1:0];
          sym_nxt = in_symbol_code;
          num_nxt = in_number_value;
          nst_nxt = in_new_state;
          res_nxt = '0;
          if (item_err) begin
            res_nxt.error_flag = 1'b1;
            state_nxt          = S_DONE;
          end else begin
            state_nxt = S_READ;
          end
        end
      end

      S_READ: begin
        state_nxt = S_DONE;
        case (cmd_r)
          CMD_SET_SYMBOL: begin
            mem_we            = 1'b1;
            mem_wdata.pattern = letter_seg(sym_r);
          end
          CMD_SET_NUMBER: begin
            quot_nxt  = QUOT_W'(product >> RECIP_SHIFT);
            state_nxt = S_DIGIT;
          end
          CMD_CLEAR: begin
            mem_we            = 1'b1;
            mem_wdata.pattern = '0;
          end
          CMD_SET_STATE: begin
            mem_we       = 1'b1;
            mem_wdata.on = nst_r;
          end
          CMD_GET_STATE: begin
            res_nxt.state_read = mem_rdata.on;
          end
          CMD_SHOW: begin
            res_nxt.segment_levels = mem_rdata.pattern ^ {7{pol}};
            res_nxt.enable_level   = mem_rdata.on ^ pol;
          end
          default: begin
            res_nxt.error_flag = 1'b1;
          end
        endcase
      end

      S_DIGIT: begin
        // Write one digit, then advance to the next display or finish
        mem_we            = 1'b1;
        mem_wdata.pattern = digit_seg(rem);
        num_nxt           = 16'(quot_r);
        if ((quot_r == '0) || (pos_r == LAST_POS)) begin
          state_nxt = S_DONE;
        end else begin
          pos_nxt   = AW'(pos_r + 1'b1);
          mem_raddr = AW'(pos_r + 1'b1);
          state_nxt = S_READ;
        end
      end

      S_DONE: begin
        // Hold the result until the output register takes it
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cmd_r  <= cmd_nxt;
    pos_r  <= pos_nxt;
    sym_r  <= sym_nxt;
    num_r  <= num_nxt;
    nst_r  <= nst_nxt;
    quot_r <= quot_nxt;
    res_r  <= res_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

endmodule
